>>> rtl/wsd_pkg.sv
package wsd_pkg;

    localparam int DEFAULT_MAX_WIDTH = 1024;

    // Nine window taps, indexed row * 3 + column, top left first.
    localparam int NTAPS  = 9;
    localparam int TAP_W  = 4;
    localparam int ROW_W  = 12;
    localparam int GEOM_W = 11;
    localparam int WROW_W = 24;
    localparam int SUM_W  = 28;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int OUT_W  = 40;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_WT_TOP = 3'd2;
    localparam logic [2:0] REG_WT_MID = 3'd3;
    localparam logic [2:0] REG_WT_BOT = 3'd4;

    localparam logic [GEOM_W-1:0] RST_WIDTH  = 11'd640;
    localparam logic [GEOM_W-1:0] RST_HEIGHT = 11'd480;
    localparam logic [WROW_W-1:0] RST_WEIGHT = 24'h010101;

    typedef struct packed {
        logic [GEOM_W-1:0]           width;
        logic [GEOM_W-1:0]           height;
        logic [2:0][WROW_W-1:0]      wts;
    } t_cfg;

    typedef struct packed {
        logic             accept;
        logic             load;
        logic             mac;
        logic [TAP_W-1:0] tap;
        logic             out_load;
        logic             advance;
    } t_cmd;

    typedef struct packed {
        logic has_result;
        logic out_free;
    } t_stat;

endpackage

>>> rtl/wsd_regs.sv
module wsd_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wsd_pkg::ADDR_W-1:0]    paddr,
    input  logic [wsd_pkg::DATA_W-1:0]    pwdata,
    output logic [wsd_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output wsd_pkg::t_cfg                 o_cfg,
    output logic                          o_geom_wr
);

    wsd_pkg::t_cfg r_cfg;
    logic [2:0]    idx;
    logic          wr;

    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= wsd_pkg::RST_WIDTH;
            r_cfg.height <= wsd_pkg::RST_HEIGHT;
            r_cfg.wts[0] <= wsd_pkg::RST_WEIGHT;
            r_cfg.wts[1] <= wsd_pkg::RST_WEIGHT;
            r_cfg.wts[2] <= wsd_pkg::RST_WEIGHT;
        end else if (wr) begin
            unique case (idx)
                wsd_pkg::REG_WIDTH:  r_cfg.width  <= pwdata[wsd_pkg::GEOM_W-1:0];
                wsd_pkg::REG_HEIGHT: r_cfg.height <= pwdata[wsd_pkg::GEOM_W-1:0];
                wsd_pkg::REG_WT_TOP: r_cfg.wts[0] <= pwdata[wsd_pkg::WROW_W-1:0];
                wsd_pkg::REG_WT_MID: r_cfg.wts[1] <= pwdata[wsd_pkg::WROW_W-1:0];
                wsd_pkg::REG_WT_BOT: r_cfg.wts[2] <= pwdata[wsd_pkg::WROW_W-1:0];
                default: ;
            endcase
        end
    end

    // A geometry write restarts the frame position.
    assign o_geom_wr = wr && ((idx == wsd_pkg::REG_WIDTH) || (idx == wsd_pkg::REG_HEIGHT));

    always_comb begin
        unique case (idx)
            wsd_pkg::REG_WIDTH:  prdata = wsd_pkg::DATA_W'(r_cfg.width);
            wsd_pkg::REG_HEIGHT: prdata = wsd_pkg::DATA_W'(r_cfg.height);
            wsd_pkg::REG_WT_TOP: prdata = wsd_pkg::DATA_W'(r_cfg.wts[0]);
            wsd_pkg::REG_WT_MID: prdata = wsd_pkg::DATA_W'(r_cfg.wts[1]);
            wsd_pkg::REG_WT_BOT: prdata = wsd_pkg::DATA_W'(r_cfg.wts[2]);
            default:             prdata = '0;
        endcase
    end

endmodule

>>> rtl/wsd_ctrl.sv
module wsd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  wsd_pkg::t_stat i_stat,
    output wsd_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_MAC  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]                r_state, n_state;
    logic [wsd_pkg::TAP_W-1:0] r_tap, n_tap;

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_tap   = r_tap;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_tap      = '0;
                if (i_stat.has_result) begin
                    n_state = S_MAC;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_MAC: begin
                // One extra step drains the last product into the sum.
                o_cmd.mac = 1'b1;
                o_cmd.tap = r_tap;
                n_tap     = r_tap + 1'b1;
                if (r_tap == wsd_pkg::TAP_W'(wsd_pkg::NTAPS)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.advance  = 1'b1;
                    n_state        = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tap   <= '0;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
        end
    end

endmodule

>>> rtl/wsd_dp.sv
module wsd_dp #(
    parameter int MAX_WIDTH = wsd_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  wsd_pkg::t_cfg              i_cfg,
    input  logic                       i_geom_wr,
    input  wsd_pkg::t_cmd              i_cmd,
    input  logic [7:0]                 i_pixel,
    input  logic                       i_drain,
    input  logic                       i_m_tready,
    output wsd_pkg::t_stat             o_stat,
    output logic                       o_m_tvalid,
    output logic [wsd_pkg::SUM_W-1:0]  o_sum,
    output logic                       o_last
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int ROW_W = wsd_pkg::ROW_W;
    localparam int NT    = wsd_pkg::NTAPS;

    logic [CW-1:0]    r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [CW:0]      ew, col_inc;
    logic [ROW_W-1:0] eh, cy;

    // Line buffer word: newer row in the high byte, older row in the low byte.
    logic [15:0] r_mem [MAX_WIDTH];
    logic [15:0] r_rd;
    logic [7:0]  r_px;
    logic [7:0]  r_win [NT];

    logic          col_nz, cv0, has_result, last;
    logic [2:0]    rv, cv;
    logic [NT-1:0] mask, r_mask;

    logic [7:0]               wt_flat [NT];
    logic [7:0]               sel_nb, sel_wt, center, diff;
    logic                     sel_on;
    logic [15:0]              r_sq;
    logic [7:0]               r_wt;
    logic [wsd_pkg::SUM_W-1:0] r_acc, r_out_sum;
    logic                     r_out_valid, r_out_last;

    always_comb begin
        if (i_cfg.width == '0) begin
            ew = (CW+1)'(1);
        end else if (int'(i_cfg.width) > MAX_WIDTH) begin
            ew = (CW+1)'(MAX_WIDTH);
        end else begin
            ew = (CW+1)'(i_cfg.width);
        end
        eh = (i_cfg.height == '0) ? ROW_W'(1) : ROW_W'(i_cfg.height);
    end

    // Window position relative to the current input position.
    assign col_nz     = (r_col != '0);
    assign cy         = r_row - (col_nz ? ROW_W'(1) : ROW_W'(2));
    assign rv         = {(cy + ROW_W'(1)) < eh, 1'b1, cy != '0};
    assign cv0        = (r_col >= CW'(2)) || (!col_nz && (ew >= (CW+1)'(2)));
    assign cv         = {col_nz, 1'b1, cv0};
    assign has_result = (r_row >= ROW_W'(2)) || ((r_row == ROW_W'(1)) && col_nz);
    assign last       = (r_row == eh + ROW_W'(1)) && !col_nz;

    always_comb begin
        for (int v = 0; v < 3; v++) begin
            for (int u = 0; u < 3; u++) begin
                mask[v*3+u]    = rv[v] & cv[u];
                wt_flat[v*3+u] = i_cfg.wts[v][8*u +: 8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rd <= r_mem[r_col];
            r_px <= i_drain ? 8'd0 : i_pixel;
        end
        if (i_cmd.load) begin
            r_mem[r_col] <= {r_px, r_rd[15:8]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NT; k++) begin
                r_win[k] <= '0;
            end
        end else if (i_cmd.load) begin
            for (int v = 0; v < 3; v++) begin
                r_win[v*3]   <= r_win[v*3+1];
                r_win[v*3+1] <= r_win[v*3+2];
            end
            r_win[2] <= r_rd[7:0];
            r_win[5] <= r_rd[15:8];
            r_win[8] <= r_px;
        end
    end

    // Tap select and absolute difference against the window center.
    always_comb begin
        sel_nb = '0;
        sel_wt = '0;
        sel_on = 1'b0;
        center = r_win[4];
        if (i_cmd.tap < wsd_pkg::TAP_W'(NT)) begin
            sel_nb = r_win[i_cmd.tap];
            sel_wt = wt_flat[i_cmd.tap];
            sel_on = r_mask[i_cmd.tap];
        end
        diff = (sel_nb > center) ? (sel_nb - center) : (center - sel_nb);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mask <= mask;
            r_sq   <= '0;
            r_wt   <= '0;
            r_acc  <= '0;
        end else if (i_cmd.mac) begin
            r_sq  <= sel_on ? (16'(diff) * 16'(diff)) : 16'd0;
            r_wt  <= sel_wt;
            r_acc <= r_acc + wsd_pkg::SUM_W'(24'(r_wt) * 24'(r_sq));
        end
    end

    always_comb begin
        col_inc = (CW+1)'(r_col) + (CW+1)'(1);
        n_col   = r_col;
        n_row   = r_row;
        if (last) begin
            n_col = '0;
            n_row = '0;
        end else if (col_inc >= ew) begin
            n_col = '0;
            n_row = r_row + ROW_W'(1);
        end else begin
            n_col = col_inc[CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_geom_wr) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cmd.advance) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_sum  <= r_acc;
            r_out_last <= last;
        end
    end

    assign o_stat.has_result = has_result;
    assign o_stat.out_free   = !r_out_valid || i_m_tready;
    assign o_m_tvalid        = r_out_valid;
    assign o_sum             = r_out_sum;
    assign o_last            = r_out_last;

endmodule

>>> rtl/weighted_squared_difference_3x3_top.sv
// An item that yields a result passes from transfer to the next accept through
// a line buffer read, a window load, ten steps of the shared tap multipliers and
// the output load, which waits while the output register holds an untaken result.
// An item without a result (start of frame) takes only the line buffer read and the window load.
// Synchronous active-low reset clears control state and restores register defaults;
// the line buffer contents are undefined until written.
module weighted_squared_difference_3x3_top #(
    parameter int MAX_WIDTH = wsd_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [7:0]                  i_s_tdata,   // [7:0] pixel
    input  logic                        i_s_tuser,   // [0] drain
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [wsd_pkg::OUT_W-1:0]   o_m_tdata,   // [7:0] value_byte, [35:8] full_sum
    output logic                        o_m_tlast,   // end_of_frame
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wsd_pkg::ADDR_W-1:0]  paddr,
    input  logic [wsd_pkg::DATA_W-1:0]  pwdata,
    output logic [wsd_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    wsd_pkg::t_cfg              cfg;
    wsd_pkg::t_cmd              cmd;
    wsd_pkg::t_stat             stat;
    logic                       geom_wr;
    logic [wsd_pkg::SUM_W-1:0]  sum;

    wsd_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_cfg     (cfg),
        .o_geom_wr (geom_wr)
    );

    wsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    wsd_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_geom_wr  (geom_wr),
        .i_cmd      (cmd),
        .i_pixel    (i_s_tdata),
        .i_drain    (i_s_tuser),
        .i_m_tready (i_m_tready),
        .o_stat     (stat),
        .o_m_tvalid (o_m_tvalid),
        .o_sum      (sum),
        .o_last     (o_m_tlast)
    );

    assign o_m_tdata = {4'd0, sum, sum[7:0]};

`ifndef ASSERT_OFF
    // One item at a time: no new transfer right after one is taken.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted while an item is in progress");

    // A result is loaded only when the output register can take it.
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("output register overwritten");

    // A loaded result is always visible on the next cycle.
    a_out_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> o_m_tvalid)
        else $error("loaded result not presented");

    // Tap steps stay within the window plus the drain step.
    a_tap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.mac |-> (cmd.tap <= wsd_pkg::TAP_W'(wsd_pkg::NTAPS)))
        else $error("tap index out of range");
`endif

endmodule
